[hw/rtl/twsm_pkg.sv]
`default_nettype none
package twsm_pkg;

	localparam int DATA_BITS = 8;
	localparam int SHIFT_W = 2 * DATA_BITS;
	localparam int HALF_W = 5;
	localparam int WAIT_W = 16;
	localparam int BIT_W = $clog2(SHIFT_W);

	localparam logic [WAIT_W-1:0] TURN_RESET = 16'd110;
	localparam logic [HALF_W-1:0] LAST_READ_HALF = HALF_W'(2 * DATA_BITS - 1);
	localparam logic [HALF_W-1:0] LAST_WRITE_HALF = HALF_W'(4 * DATA_BITS - 1);

	localparam int CMD_DEPTH = 2;
	localparam int RES_DEPTH = 2;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		K_TICK,
		K_WRITE,
		K_READ
	} kind_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SEND,
		PH_WAIT1,
		PH_RECV,
		PH_WAIT2
	} phase_t;

	typedef struct packed {
		kind_t                kind;
		logic [6:0]           reg_address;
		logic [DATA_BITS-1:0] write_value;
		logic                 line_in;
	} cmd_t;

	typedef struct packed {
		logic                 clock_line;
		logic                 data_out;
		logic                 data_enable;
		logic                 busy_res;
		logic                 done_res;
		logic [DATA_BITS-1:0] read_value;
	} res_t;

endpackage
`default_nettype wire

[hw/rtl/twsm_fifo.sv]
`default_nettype none
module twsm_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             rd_en,
	output logic      [WIDTH-1:0] rd_data,
	output logic                  empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

[hw/rtl/twsm_front.sv]
`default_nettype none
module twsm_front #(
	parameter int CMD_DEPTH = twsm_pkg::CMD_DEPTH
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           push,
	output logic                                full,
	input  wire logic [1:0]                     operation,
	input  wire logic [6:0]                     reg_address,
	input  wire logic [twsm_pkg::DATA_BITS-1:0] write_value,
	input  wire logic                           line_in,
	input  wire logic                           cmd_pop,
	output twsm_pkg::cmd_t                      cmd,
	output logic                                cmd_valid
);

	twsm_pkg::cmd_t cmd_in;
	logic           cmd_empty;

	// operation three falls through to a plain tick
	always_comb begin
		cmd_in.reg_address = reg_address;
		cmd_in.write_value = write_value;
		cmd_in.line_in     = line_in;
		case (operation)
			twsm_pkg::OP_WRITE: cmd_in.kind = twsm_pkg::K_WRITE;
			twsm_pkg::OP_READ:  cmd_in.kind = twsm_pkg::K_READ;
			default:            cmd_in.kind = twsm_pkg::K_TICK;
		endcase
	end

	twsm_fifo #(
		.WIDTH($bits(twsm_pkg::cmd_t)),
		.DEPTH(CMD_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (push),
		.wr_data(cmd_in),
		.full   (full),
		.rd_en  (cmd_pop),
		.rd_data(cmd),
		.empty  (cmd_empty)
	);

	assign cmd_valid = !cmd_empty;

endmodule
`default_nettype wire

[hw/rtl/twsm_back.sv]
`default_nettype none
module twsm_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        turnaround_we,
	input  wire logic [twsm_pkg::WAIT_W-1:0] turnaround_ticks,
	input  wire logic                        cmd_valid,
	input  wire twsm_pkg::cmd_t              cmd,
	output logic                             cmd_pop,
	input  wire logic                        res_full,
	output logic                             res_push,
	output twsm_pkg::res_t                   res
);

	localparam int DB = twsm_pkg::DATA_BITS;
	localparam int SW = twsm_pkg::SHIFT_W;
	localparam int HW = twsm_pkg::HALF_W;
	localparam int WW = twsm_pkg::WAIT_W;
	localparam int BW = twsm_pkg::BIT_W;

	logic [WW-1:0]     turn_q;
	twsm_pkg::phase_t  phase_q, phase_n;
	logic [HW-1:0]     half_q, half_n;
	logic [WW-1:0]     wait_q, wait_n;
	logic [SW-1:0]     sout_q, sout_n;
	logic [DB-1:0]     sin_q, sin_n;
	logic              is_read_q, is_read_n;
	logic              clk_lvl_q, clk_lvl_n;
	logic              done;
	logic              fire;
	logic              start;
	logic              wr;
	logic [HW-1:0]     last_half;
	logic [HW-1:0]     half_m1;
	logic [BW-1:0]     bit_sel;

	assign fire     = cmd_valid && !res_full;
	assign cmd_pop  = fire;
	assign res_push = fire;
	assign start    = (cmd.kind != twsm_pkg::K_TICK);
	assign wr       = (cmd.kind == twsm_pkg::K_WRITE);
	assign last_half = is_read_q ? twsm_pkg::LAST_READ_HALF : twsm_pkg::LAST_WRITE_HALF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			turn_q <= twsm_pkg::TURN_RESET;
		end else if (turnaround_we) begin
			turn_q <= turnaround_ticks;
		end
	end

	// next state for one item
	always_comb begin
		phase_n   = phase_q;
		half_n    = half_q;
		wait_n    = wait_q;
		sout_n    = sout_q;
		sin_n     = sin_q;
		is_read_n = is_read_q;
		clk_lvl_n = clk_lvl_q;
		done      = 1'b0;
		case (phase_q)
			twsm_pkg::PH_IDLE: begin
				if (start) begin
					is_read_n = !wr;
					sout_n    = {wr, cmd.reg_address, (wr ? cmd.write_value : {DB{1'b0}})};
					sin_n     = '0;
					half_n    = '0;
					clk_lvl_n = 1'b1;
					phase_n   = twsm_pkg::PH_SEND;
				end
			end
			twsm_pkg::PH_SEND: begin
				if (!start) begin
					clk_lvl_n = half_q[0];
					if (half_q >= last_half) begin
						if (is_read_q) begin
							if (turn_q == '0) begin
								phase_n = twsm_pkg::PH_RECV;
								half_n  = '0;
							end else begin
								phase_n = twsm_pkg::PH_WAIT1;
								wait_n  = turn_q;
							end
						end else begin
							phase_n = twsm_pkg::PH_IDLE;
							done    = 1'b1;
						end
					end else begin
						half_n = half_q + 1'b1;
					end
				end
			end
			twsm_pkg::PH_RECV: begin
				if (!start) begin
					clk_lvl_n = half_q[0];
					if (half_q[0]) begin
						sin_n = {sin_q[DB-2:0], cmd.line_in};
					end
					if (half_q >= twsm_pkg::LAST_READ_HALF) begin
						if (turn_q == '0) begin
							phase_n = twsm_pkg::PH_IDLE;
							done    = 1'b1;
						end else begin
							phase_n = twsm_pkg::PH_WAIT2;
							wait_n  = turn_q;
						end
					end else begin
						half_n = half_q + 1'b1;
					end
				end
			end
			twsm_pkg::PH_WAIT1, twsm_pkg::PH_WAIT2: begin
				if (!start) begin
					if (wait_q != '0) begin
						wait_n = wait_q - 1'b1;
					end
					if (wait_n == '0) begin
						if (phase_q == twsm_pkg::PH_WAIT1) begin
							phase_n = twsm_pkg::PH_RECV;
							half_n  = '0;
						end else begin
							phase_n = twsm_pkg::PH_IDLE;
							done    = 1'b1;
						end
					end
				end
			end
			default: begin
				phase_n = twsm_pkg::PH_IDLE;
			end
		endcase
	end

	// the first half of each bit shows that bit, later halves lag one half
	always_comb begin
		half_m1 = half_n - 1'b1;
		bit_sel = (half_n == '0) ? '0 : half_m1[BW:1];
		res.clock_line  = clk_lvl_n;
		res.data_enable = (phase_n == twsm_pkg::PH_SEND);
		res.data_out    = res.data_enable ? sout_n[BW'(SW - 1) - bit_sel] : 1'b0;
		res.busy_res    = (phase_n != twsm_pkg::PH_IDLE);
		res.done_res    = done;
		res.read_value  = (done && is_read_n) ? sin_n : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= twsm_pkg::PH_IDLE;
			half_q    <= '0;
			wait_q    <= '0;
			sout_q    <= '0;
			sin_q     <= '0;
			is_read_q <= 1'b0;
			clk_lvl_q <= 1'b1;
		end else if (fire) begin
			phase_q   <= phase_n;
			half_q    <= half_n;
			wait_q    <= wait_n;
			sout_q    <= sout_n;
			sin_q     <= sin_n;
			is_read_q <= is_read_n;
			clk_lvl_q <= clk_lvl_n;
		end
	end

`ifndef ASSERT_OFF
	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fire && done |=> phase_q == twsm_pkg::PH_IDLE)
		else $error("transfer completed but engine not idle");

	a_idle_clock_high: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == twsm_pkg::PH_IDLE |-> clk_lvl_q)
		else $error("clock line low while idle");

	a_wait_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == twsm_pkg::PH_WAIT1 || phase_q == twsm_pkg::PH_WAIT2) |-> wait_q != '0)
		else $error("turnaround wait with zero count");

	a_recv_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == twsm_pkg::PH_RECV |-> half_q <= twsm_pkg::LAST_READ_HALF)
		else $error("receive half-bit count out of range");

	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(phase_q) && $stable(half_q) && $stable(wait_q))
		else $error("engine moved without a beat");
`endif

endmodule
`default_nettype wire

[hw/rtl/two_wire_register_serial_master_unit.sv]
// two-wire register serial master: clock line plus one half-duplex data line
//
// input queue: drive operation, reg_address, write_value, line_in with push;
// a beat is taken on a clock edge with push high and full low. every beat is
// one tick (one half-bit of the serial clock) or a start of a register write
// or read. a start during a transfer is dropped and does not advance it.
// result queue: one result beat per input beat, in order. it is on the
// result ports while empty is low and leaves on an edge with pop high.
// each result shows the line levels after its tick, plus busy and a done
// pulse; read_value holds the received byte on the done beat of a read.
// turnaround_we with turnaround_ticks sets the read turnaround wait (reset
// 110 ticks); write it only while no transfer is in flight.
// a result reaches the result ports after its input beat is stored in the
// command queue and then moved into the result queue; the engine steps as the
// beat moves from the command queue into the result queue. throughput is one
// beat per cycle while the result queue is not full, set by the engine step.
// reset empties both queues and leaves the engine idle, clock high, data
// released. when pop is held low the result queue fills, the engine stops,
// then the command queue fills and full goes high.
`default_nettype none
module two_wire_register_serial_master_unit #(
	parameter int CMD_DEPTH = twsm_pkg::CMD_DEPTH,
	parameter int RES_DEPTH = twsm_pkg::RES_DEPTH
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           turnaround_we,
	input  wire logic [twsm_pkg::WAIT_W-1:0]    turnaround_ticks,
	input  wire logic                           push,
	output logic                                full,
	input  wire logic [1:0]                     operation,
	input  wire logic [6:0]                     reg_address,
	input  wire logic [twsm_pkg::DATA_BITS-1:0] write_value,
	input  wire logic                           line_in,
	output logic                                empty,
	input  wire logic                           pop,
	output logic                                clock_line,
	output logic                                data_out,
	output logic                                data_enable,
	output logic                                busy_res,
	output logic                                done_res,
	output logic [twsm_pkg::DATA_BITS-1:0]      read_value
);

	twsm_pkg::cmd_t cmd;
	logic           cmd_valid;
	logic           cmd_pop;
	logic           res_full;
	logic           res_push;
	twsm_pkg::res_t res_in;
	twsm_pkg::res_t res_out;

	twsm_front #(
		.CMD_DEPTH(CMD_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.operation  (operation),
		.reg_address(reg_address),
		.write_value(write_value),
		.line_in    (line_in),
		.cmd_pop    (cmd_pop),
		.cmd        (cmd),
		.cmd_valid  (cmd_valid)
	);

	twsm_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.turnaround_we   (turnaround_we),
		.turnaround_ticks(turnaround_ticks),
		.cmd_valid       (cmd_valid),
		.cmd             (cmd),
		.cmd_pop         (cmd_pop),
		.res_full        (res_full),
		.res_push        (res_push),
		.res             (res_in)
	);

	twsm_fifo #(
		.WIDTH($bits(twsm_pkg::res_t)),
		.DEPTH(RES_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (res_push),
		.wr_data(res_in),
		.full   (res_full),
		.rd_en  (pop),
		.rd_data(res_out),
		.empty  (empty)
	);

	assign clock_line  = res_out.clock_line;
	assign data_out    = res_out.data_out;
	assign data_enable = res_out.data_enable;
	assign busy_res    = res_out.busy_res;
	assign done_res    = res_out.done_res;
	assign read_value  = res_out.read_value;

endmodule
`default_nettype wire
